[src/joystick_deadband_moving_average_unit_defines.svh]
// Assertion helpers for the joystick filter
`ifndef JOYSTICK_DEADBAND_MOVING_AVERAGE_UNIT_DEFINES_SVH
`define JOYSTICK_DEADBAND_MOVING_AVERAGE_UNIT_DEFINES_SVH

// same-cycle implication
`define JDMA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("jdma assertion failed");

// next-cycle implication
`define JDMA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("jdma assertion failed");

`endif

[src/jdma_pkg.sv]
`default_nettype none

package jdma_pkg;

    localparam int SAMPLE_BITS = 10;
    localparam int REG_BITS    = 10;
    localparam int AVG_DEPTH   = 8;
    localparam int STICKS      = 2;
    localparam int STICK_BITS  = 1;
    localparam int POS_BITS    = $clog2(AVG_DEPTH);
    localparam int SUM_BITS    = SAMPLE_BITS + POS_BITS;
    localparam int DIFF_BITS   = SAMPLE_BITS + 1;
    localparam int SQ_BITS     = 2 * SAMPLE_BITS;
    localparam int DIR_BITS    = 2;

    localparam int IN_TDATA_BITS  = ((2 * SAMPLE_BITS + 7) / 8) * 8;
    localparam int OUT_TDATA_BITS = ((2 * SAMPLE_BITS + 2 * DIR_BITS + 7) / 8) * 8;

    localparam int APB_DATA_BITS = 32;
    localparam int APB_ADDR_BITS = 5;
    localparam int REG_IDX_BITS  = APB_ADDR_BITS - 2;

    localparam logic [REG_IDX_BITS-1:0] REG_CENTRE_X0 = 3'd0;
    localparam logic [REG_IDX_BITS-1:0] REG_CENTRE_Y0 = 3'd1;
    localparam logic [REG_IDX_BITS-1:0] REG_CENTRE_X1 = 3'd2;
    localparam logic [REG_IDX_BITS-1:0] REG_CENTRE_Y1 = 3'd3;
    localparam logic [REG_IDX_BITS-1:0] REG_DEAD_RAD  = 3'd4;
    localparam logic [REG_IDX_BITS-1:0] REG_DIR_MARG  = 3'd5;

    localparam logic [REG_BITS-1:0] CENTRE_RESET = 10'd512;
    localparam logic [REG_BITS-1:0] RADIUS_RESET = 10'd50;
    localparam logic [REG_BITS-1:0] MARGIN_RESET = 10'd25;

    localparam logic [DIR_BITS-1:0] DIR_NONE = 2'd0;
    localparam logic [DIR_BITS-1:0] DIR_LOW  = 2'd1;
    localparam logic [DIR_BITS-1:0] DIR_HIGH = 2'd2;

    typedef struct packed {
        logic [STICKS-1:0][REG_BITS-1:0] centre_x;
        logic [STICKS-1:0][REG_BITS-1:0] centre_y;
        logic [REG_BITS-1:0]             dead_radius;
        logic [REG_BITS-1:0]             margin;
    } t_cfg;

endpackage

`default_nettype wire

[src/joystick_deadband_moving_average_unit.sv]
// Radial deadband and 8-sample moving average for two joysticks. Each input word carries one
// raw X/Y pair and the stick number; a pair counts only when its squared distance from that
// stick's centre register is above the squared deadband radius, and then replaces the oldest
// of the stick's last eight pairs. Every word yields one result word: the accepted flag, the
// stick's truncated X/Y averages and left/right and down/up codes, with the direction margin
// inclusive; a rejected pair leaves all state alone and reports no direction. An input word
// is registered, filtered in one pass and stored in the result register, so its result word
// is offered once it has passed through the input register and the result register; one word
// can be taken every cycle while the result side keeps up; a stalled result holds the input
// register, which then stalls the input side. Reset clears the rings and sums at once; no
// clearing pass follows. Registers sit on the APB port at byte offsets 0 to 20.
`default_nettype none
`include "joystick_deadband_moving_average_unit_defines.svh"

module joystick_deadband_moving_average_unit (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // slave side
    input  logic                                   i_s_tvalid,
    output logic                                   o_s_tready,
    input  logic [jdma_pkg::IN_TDATA_BITS-1:0]     i_s_tdata,  // raw_x, raw_y, zero pad
    input  logic [jdma_pkg::STICK_BITS-1:0]        i_s_tuser,  // stick
    // master side
    output logic                                   o_m_tvalid,
    input  logic                                   i_m_tready,
    output logic [jdma_pkg::OUT_TDATA_BITS-1:0]    o_m_tdata,  // mean_x, mean_y, dir_x, dir_y
    output logic                                   o_m_tuser,  // accepted
    // configuration
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [jdma_pkg::APB_ADDR_BITS-1:0]     paddr,
    input  logic [jdma_pkg::APB_DATA_BITS-1:0]     pwdata,
    output logic [jdma_pkg::APB_DATA_BITS-1:0]     prdata,
    output logic                                   pready
);
    import jdma_pkg::*;

    t_cfg                   w_cfg;

    logic                   r_in_valid;
    logic [STICK_BITS-1:0]  r_stick;
    logic [SAMPLE_BITS-1:0] r_raw_x;
    logic [SAMPLE_BITS-1:0] r_raw_y;

    logic                   r_out_valid;
    logic                   r_accepted;
    logic [SAMPLE_BITS-1:0] r_mean_x;
    logic [SAMPLE_BITS-1:0] r_mean_y;
    logic [DIR_BITS-1:0]    r_dir_x;
    logic [DIR_BITS-1:0]    r_dir_y;

    logic                   w_advance;
    logic                   w_take;
    logic                   w_outside;
    logic [REG_BITS-1:0]    w_centre_x;
    logic [REG_BITS-1:0]    w_centre_y;
    logic [SAMPLE_BITS-1:0] w_mean_x;
    logic [SAMPLE_BITS-1:0] w_mean_y;
    logic [DIR_BITS-1:0]    w_dir_x;
    logic [DIR_BITS-1:0]    w_dir_y;

    jdma_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    assign w_advance  = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || w_advance;
    assign w_take     = i_s_tvalid && o_s_tready;

    assign w_centre_x = w_cfg.centre_x[r_stick];
    assign w_centre_y = w_cfg.centre_y[r_stick];

    jdma_deadband u_deadband (
        .i_raw_x    (r_raw_x),
        .i_raw_y    (r_raw_y),
        .i_centre_x (w_centre_x),
        .i_centre_y (w_centre_y),
        .i_radius   (w_cfg.dead_radius),
        .o_outside  (w_outside)
    );

    jdma_avg u_avg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_commit  (w_advance),
        .i_outside (w_outside),
        .i_stick   (r_stick),
        .i_raw_x   (r_raw_x),
        .i_raw_y   (r_raw_y),
        .o_mean_x  (w_mean_x),
        .o_mean_y  (w_mean_y)
    );

    jdma_dir u_dir_x (
        .i_valid  (w_outside),
        .i_mean   (w_mean_x),
        .i_centre (w_centre_x),
        .i_margin (w_cfg.margin),
        .o_dir    (w_dir_x)
    );

    jdma_dir u_dir_y (
        .i_valid  (w_outside),
        .i_mean   (w_mean_y),
        .i_centre (w_centre_y),
        .i_margin (w_cfg.margin),
        .o_dir    (w_dir_y)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_stick <= i_s_tuser;
            r_raw_x <= i_s_tdata[SAMPLE_BITS-1:0];
            r_raw_y <= i_s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_accepted <= w_outside;
            r_mean_x   <= w_mean_x;
            r_mean_y   <= w_mean_y;
            r_dir_x    <= w_dir_x;
            r_dir_y    <= w_dir_y;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_accepted;
    assign o_m_tdata  = OUT_TDATA_BITS'({r_dir_y, r_dir_x, r_mean_y, r_mean_x});

    `JDMA_ASSERT_NOW(a_reject_no_dir, i_clk, i_rst_n,
        r_out_valid && !r_accepted, (r_dir_x == DIR_NONE) && (r_dir_y == DIR_NONE))
    `JDMA_ASSERT_NOW(a_dir_code_legal, i_clk, i_rst_n,
        r_out_valid,
        ((r_dir_x == DIR_NONE) || (r_dir_x == DIR_LOW) || (r_dir_x == DIR_HIGH)) &&
        ((r_dir_y == DIR_NONE) || (r_dir_y == DIR_LOW) || (r_dir_y == DIR_HIGH)))
    `JDMA_ASSERT_NOW(a_full_stall_blocks, i_clk, i_rst_n,
        r_in_valid && r_out_valid && !i_m_tready, !o_s_tready)
    `JDMA_ASSERT_NEXT(a_advance_fills_out, i_clk, i_rst_n,
        w_advance, r_out_valid)

endmodule

`default_nettype wire

[src/jdma_regs.sv]
`default_nettype none

module jdma_regs (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [jdma_pkg::APB_ADDR_BITS-1:0] paddr,
    input  logic [jdma_pkg::APB_DATA_BITS-1:0] pwdata,
    output logic [jdma_pkg::APB_DATA_BITS-1:0] prdata,
    output logic                               pready,
    output jdma_pkg::t_cfg                     o_cfg
);
    import jdma_pkg::*;

    t_cfg                    r_cfg;
    logic [REG_IDX_BITS-1:0] w_idx;
    logic                    w_wr;
    logic [REG_BITS-1:0]     w_rd;

    assign w_idx  = paddr[APB_ADDR_BITS-1:2];
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.centre_x    <= {STICKS{CENTRE_RESET}};
            r_cfg.centre_y    <= {STICKS{CENTRE_RESET}};
            r_cfg.dead_radius <= RADIUS_RESET;
            r_cfg.margin      <= MARGIN_RESET;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_CENTRE_X0: r_cfg.centre_x[0]  <= pwdata[REG_BITS-1:0];
                REG_CENTRE_Y0: r_cfg.centre_y[0]  <= pwdata[REG_BITS-1:0];
                REG_CENTRE_X1: r_cfg.centre_x[1]  <= pwdata[REG_BITS-1:0];
                REG_CENTRE_Y1: r_cfg.centre_y[1]  <= pwdata[REG_BITS-1:0];
                REG_DEAD_RAD:  r_cfg.dead_radius  <= pwdata[REG_BITS-1:0];
                REG_DIR_MARG:  r_cfg.margin       <= pwdata[REG_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_CENTRE_X0: w_rd = r_cfg.centre_x[0];
            REG_CENTRE_Y0: w_rd = r_cfg.centre_y[0];
            REG_CENTRE_X1: w_rd = r_cfg.centre_x[1];
            REG_CENTRE_Y1: w_rd = r_cfg.centre_y[1];
            REG_DEAD_RAD:  w_rd = r_cfg.dead_radius;
            REG_DIR_MARG:  w_rd = r_cfg.margin;
            default:       w_rd = '0;
        endcase
    end

    assign prdata = APB_DATA_BITS'(w_rd);

endmodule

`default_nettype wire

[src/jdma_deadband.sv]
`default_nettype none

module jdma_deadband (
    input  logic [jdma_pkg::SAMPLE_BITS-1:0] i_raw_x,
    input  logic [jdma_pkg::SAMPLE_BITS-1:0] i_raw_y,
    input  logic [jdma_pkg::REG_BITS-1:0]    i_centre_x,
    input  logic [jdma_pkg::REG_BITS-1:0]    i_centre_y,
    input  logic [jdma_pkg::REG_BITS-1:0]    i_radius,
    output logic                             o_outside
);
    import jdma_pkg::*;

    logic signed [DIFF_BITS-1:0]   w_dx;
    logic signed [DIFF_BITS-1:0]   w_dy;
    logic signed [2*DIFF_BITS-1:0] w_sq_x;
    logic signed [2*DIFF_BITS-1:0] w_sq_y;
    logic        [SQ_BITS:0]       w_dist;
    logic        [SQ_BITS-1:0]     w_rad_sq;

    assign w_dx = $signed({1'b0, i_raw_x}) - $signed({1'b0, i_centre_x});
    assign w_dy = $signed({1'b0, i_raw_y}) - $signed({1'b0, i_centre_y});

    assign w_sq_x = w_dx * w_dx;
    assign w_sq_y = w_dy * w_dy;

    assign w_dist   = {1'b0, w_sq_x[SQ_BITS-1:0]} + {1'b0, w_sq_y[SQ_BITS-1:0]};
    assign w_rad_sq = SQ_BITS'(i_radius) * SQ_BITS'(i_radius);

    assign o_outside = w_dist > {1'b0, w_rad_sq};

endmodule

`default_nettype wire

[src/jdma_avg.sv]
`default_nettype none

module jdma_avg (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_commit,
    input  logic                             i_outside,
    input  logic [jdma_pkg::STICK_BITS-1:0]  i_stick,
    input  logic [jdma_pkg::SAMPLE_BITS-1:0] i_raw_x,
    input  logic [jdma_pkg::SAMPLE_BITS-1:0] i_raw_y,
    output logic [jdma_pkg::SAMPLE_BITS-1:0] o_mean_x,
    output logic [jdma_pkg::SAMPLE_BITS-1:0] o_mean_y
);
    import jdma_pkg::*;

    logic [SAMPLE_BITS-1:0] r_ring_x [STICKS][AVG_DEPTH];
    logic [SAMPLE_BITS-1:0] r_ring_y [STICKS][AVG_DEPTH];
    logic [SUM_BITS-1:0]    r_sum_x  [STICKS];
    logic [SUM_BITS-1:0]    r_sum_y  [STICKS];
    logic [POS_BITS-1:0]    r_pos    [STICKS];

    logic [POS_BITS-1:0]    w_pos;
    logic [POS_BITS-1:0]    n_pos;
    logic [SUM_BITS-1:0]    n_sum_x;
    logic [SUM_BITS-1:0]    n_sum_y;
    logic [SUM_BITS-1:0]    w_sum_x;
    logic [SUM_BITS-1:0]    w_sum_y;
    logic                   w_update;

    assign w_pos    = r_pos[i_stick];
    assign n_pos    = (w_pos == POS_BITS'(AVG_DEPTH - 1)) ? '0 : w_pos + 1'b1;
    assign n_sum_x  = r_sum_x[i_stick] - SUM_BITS'(r_ring_x[i_stick][w_pos])
                      + SUM_BITS'(i_raw_x);
    assign n_sum_y  = r_sum_y[i_stick] - SUM_BITS'(r_ring_y[i_stick][w_pos])
                      + SUM_BITS'(i_raw_y);
    assign w_sum_x  = i_outside ? n_sum_x : r_sum_x[i_stick];
    assign w_sum_y  = i_outside ? n_sum_y : r_sum_y[i_stick];
    assign o_mean_x = w_sum_x[SUM_BITS-1:POS_BITS];
    assign o_mean_y = w_sum_y[SUM_BITS-1:POS_BITS];
    assign w_update = i_commit && i_outside;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < STICKS; s++) begin
                r_sum_x[s] <= '0;
                r_sum_y[s] <= '0;
                r_pos[s]   <= '0;
                for (int k = 0; k < AVG_DEPTH; k++) begin
                    r_ring_x[s][k] <= '0;
                    r_ring_y[s][k] <= '0;
                end
            end
        end else if (w_update) begin
            r_sum_x[i_stick]         <= n_sum_x;
            r_sum_y[i_stick]         <= n_sum_y;
            r_pos[i_stick]           <= n_pos;
            r_ring_x[i_stick][w_pos] <= i_raw_x;
            r_ring_y[i_stick][w_pos] <= i_raw_y;
        end
    end

endmodule

`default_nettype wire

[src/jdma_dir.sv]
`default_nettype none

module jdma_dir (
    input  logic                             i_valid,
    input  logic [jdma_pkg::SAMPLE_BITS-1:0] i_mean,
    input  logic [jdma_pkg::REG_BITS-1:0]    i_centre,
    input  logic [jdma_pkg::REG_BITS-1:0]    i_margin,
    output logic [jdma_pkg::DIR_BITS-1:0]    o_dir
);
    import jdma_pkg::*;

    logic [REG_BITS:0] w_mean;
    logic [REG_BITS:0] w_lo_lhs;
    logic [REG_BITS:0] w_hi_rhs;

    assign w_mean   = (REG_BITS + 1)'(i_mean);
    assign w_lo_lhs = w_mean + {1'b0, i_margin};
    assign w_hi_rhs = {1'b0, i_centre} + {1'b0, i_margin};

    always_comb begin
        priority if (!i_valid) begin
            o_dir = DIR_NONE;
        end else if (w_lo_lhs < {1'b0, i_centre}) begin
            o_dir = DIR_LOW;
        end else if (w_mean > w_hi_rhs) begin
            o_dir = DIR_HIGH;
        end else begin
            o_dir = DIR_NONE;
        end
    end

endmodule

`default_nettype wire

[bench/tb.sv]
`default_nettype none

module tb;
    import jdma_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int PHASE_WORDS  = 100;
    localparam int TAIL_CYCLES  = 6;

    typedef struct packed {
        logic                accepted;
        logic [REG_BITS-1:0] mean_x;
        logic [REG_BITS-1:0] mean_y;
        logic [DIR_BITS-1:0] dir_x;
        logic [DIR_BITS-1:0] dir_y;
    } t_stick_report;

    class stick_filter_predictor;
        logic [REG_BITS-1:0]    centre_x [STICKS];
        logic [REG_BITS-1:0]    centre_y [STICKS];
        logic [REG_BITS-1:0]    radius;
        logic [REG_BITS-1:0]    margin;
        logic [SAMPLE_BITS-1:0] ring_x [STICKS][AVG_DEPTH];
        logic [SAMPLE_BITS-1:0] ring_y [STICKS][AVG_DEPTH];
        int                     sum_x [STICKS];
        int                     sum_y [STICKS];
        int                     slot [STICKS];
        logic [REG_BITS-1:0]    held_x [STICKS];
        logic [REG_BITS-1:0]    held_y [STICKS];
        t_stick_report          pending_reports [$];
        int                     mismatches;

        function new();
            for (int s = 0; s < STICKS; s++) begin
                centre_x[s] = CENTRE_RESET;
                centre_y[s] = CENTRE_RESET;
                sum_x[s]    = 0;
                sum_y[s]    = 0;
                slot[s]     = 0;
                held_x[s]   = '0;
                held_y[s]   = '0;
                for (int k = 0; k < AVG_DEPTH; k++) begin
                    ring_x[s][k] = '0;
                    ring_y[s][k] = '0;
                end
            end
            radius     = RADIUS_RESET;
            margin     = MARGIN_RESET;
            mismatches = 0;
        endfunction

        function void write_reg(logic [REG_IDX_BITS-1:0] idx, logic [REG_BITS-1:0] value);
            case (idx)
                REG_CENTRE_X0: centre_x[0] = value;
                REG_CENTRE_Y0: centre_y[0] = value;
                REG_CENTRE_X1: centre_x[1] = value;
                REG_CENTRE_Y1: centre_y[1] = value;
                REG_DEAD_RAD:  radius      = value;
                REG_DIR_MARG:  margin      = value;
                default: ;
            endcase
        endfunction

        function logic [DIR_BITS-1:0] direction(int mean, int centre, int gap);
            if (mean < centre - gap) return DIR_LOW;
            if (mean > centre + gap) return DIR_HIGH;
            return DIR_NONE;
        endfunction

        function void take_sample(bit s, logic [SAMPLE_BITS-1:0] x,
                                  logic [SAMPLE_BITS-1:0] y);
            int            dx;
            int            dy;
            int            p;
            t_stick_report r;
            dx = int'(x) - int'(centre_x[s]);
            dy = int'(y) - int'(centre_y[s]);
            r  = '0;
            if (dx * dx + dy * dy > int'(radius) * int'(radius)) begin
                p = slot[s];
                sum_x[s] = sum_x[s] - int'(ring_x[s][p]) + int'(x);
                sum_y[s] = sum_y[s] - int'(ring_y[s][p]) + int'(y);
                ring_x[s][p] = x;
                ring_y[s][p] = y;
                slot[s]   = (p + 1) % AVG_DEPTH;
                held_x[s] = REG_BITS'(sum_x[s] / AVG_DEPTH);
                held_y[s] = REG_BITS'(sum_y[s] / AVG_DEPTH);
                r.accepted = 1'b1;
                r.dir_x = direction(int'(held_x[s]), int'(centre_x[s]), int'(margin));
                r.dir_y = direction(int'(held_y[s]), int'(centre_y[s]), int'(margin));
            end
            r.mean_x = held_x[s];
            r.mean_y = held_y[s];
            pending_reports.push_back(r);
        endfunction

        function void check_report(logic [OUT_TDATA_BITS-1:0] tdata, logic tuser);
            t_stick_report got;
            t_stick_report want;
            got.accepted = tuser;
            got.mean_x   = tdata[9:0];
            got.mean_y   = tdata[19:10];
            got.dir_x    = tdata[21:20];
            got.dir_y    = tdata[23:22];
            if (pending_reports.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word acc=%0d mx=%0d my=%0d dx=%0d dy=%0d",
                             got.accepted, got.mean_x, got.mean_y, got.dir_x, got.dir_y);
                return;
            end
            want = pending_reports.pop_front();
            if (got.accepted != want.accepted || got.mean_x != want.mean_x ||
                got.mean_y != want.mean_y || got.dir_x != want.dir_x ||
                got.dir_y != want.dir_y) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"mismatch: exp acc=%0d mx=%0d my=%0d dx=%0d dy=%0d,",
                              " got acc=%0d mx=%0d my=%0d dx=%0d dy=%0d"},
                             want.accepted, want.mean_x, want.mean_y, want.dir_x,
                             want.dir_y, got.accepted, got.mean_x, got.mean_y,
                             got.dir_x, got.dir_y);
            end
        endfunction
    endclass

    logic                      i_clk = 1'b0;
    logic                      i_rst_n;
    logic                      i_s_tvalid;
    logic                      o_s_tready;
    logic [IN_TDATA_BITS-1:0]  i_s_tdata;   // raw_x, raw_y, zero pad
    logic [STICK_BITS-1:0]     i_s_tuser;   // stick
    logic                      o_m_tvalid;
    logic                      i_m_tready;
    logic [OUT_TDATA_BITS-1:0] o_m_tdata;   // mean_x, mean_y, dir_x, dir_y
    logic                      o_m_tuser;   // accepted
    logic                      psel;
    logic                      penable;
    logic                      pwrite;
    logic [APB_ADDR_BITS-1:0]  paddr;
    logic [APB_DATA_BITS-1:0]  pwdata;
    logic [APB_DATA_BITS-1:0]  prdata;
    logic                      pready;

    stick_filter_predictor filt = new();
    int  cycle_count = 0;
    int  hold_cycles = 0;
    int  rx_wait     = 0;
    bit  rx_quiet    = 1'b0;
    bit  tx_quiet    = 1'b0;

    joystick_deadband_moving_average_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            filt.check_report(o_m_tdata, o_m_tuser);
            rx_wait = rx_quiet ? 0 : $urandom_range(0, 14);
        end
    end

    // hold off the result side for a long stretch when asked, else stall per word
    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            i_m_tready <= 1'b0;
            hold_cycles--;
        end else if (rx_wait > 0) begin
            i_m_tready <= 1'b0;
            rx_wait--;
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    task automatic apb_write(input logic [REG_IDX_BITS-1:0] idx,
                             input logic [REG_BITS-1:0]     value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {{(APB_DATA_BITS-REG_BITS){1'b0}}, value};
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        filt.write_reg(idx, value);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_centres(input logic [REG_BITS-1:0] x0, input logic [REG_BITS-1:0] y0,
                               input logic [REG_BITS-1:0] x1, input logic [REG_BITS-1:0] y1,
                               input logic [REG_BITS-1:0] rad, input logic [REG_BITS-1:0] marg);
        apb_write(REG_CENTRE_X0, x0);
        apb_write(REG_CENTRE_Y0, y0);
        apb_write(REG_CENTRE_X1, x1);
        apb_write(REG_CENTRE_Y1, y1);
        apb_write(REG_DEAD_RAD, rad);
        apb_write(REG_DIR_MARG, marg);
    endtask

    task automatic send_sample(input bit s, input int x, input int y);
        int gap;
        gap = tx_quiet ? 0 : $urandom_range(0, 14);
        repeat (gap) begin
            @(negedge i_clk);
            i_s_tvalid <= 1'b0;
        end
        @(negedge i_clk);
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {4'b0, 10'(y), 10'(x)};
        i_s_tuser  <= s;
        do @(posedge i_clk); while (!o_s_tready);
        filt.take_sample(s, 10'(x), 10'(y));
    endtask

    task automatic stop_sending();
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (filt.pending_reports.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
    endtask

    function automatic int axis_sample(logic [REG_BITS-1:0] centre, bit near);
        int v;
        if (!near) return $urandom_range(0, 1023);
        v = int'(centre) + $urandom_range(0, 2 * int'(filt.radius) + 4) - (int'(filt.radius) + 2);
        if (v < 0) v = 0;
        if (v > 1023) v = 1023;
        return v;
    endfunction

    function automatic logic [REG_BITS-1:0] rand_reg(int lo, int hi);
        return REG_BITS'($urandom_range(lo, hi));
    endfunction

    task automatic random_samples(input int count);
        bit s;
        bit near;
        for (int n = 0; n < count; n++) begin
            if (n % 25 == 0) begin
                tx_quiet = ($urandom_range(0, 3) == 0);
                rx_quiet = ($urandom_range(0, 3) == 0);
            end
            s    = 1'($urandom_range(0, 1));
            near = ($urandom_range(0, 2) == 0);
            send_sample(s, axis_sample(filt.centre_x[s], near),
                        axis_sample(filt.centre_y[s], near));
        end
        stop_sending();
    endtask

    initial begin
        i_rst_n    = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata  = '0;
        i_s_tuser  = '0;
        i_m_tready = 1'b0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: centre, deadband edge, extremes, margin edges
        send_sample(1'b0, 512, 512);
        send_sample(1'b0, 562, 512);
        send_sample(1'b0, 563, 512);
        send_sample(1'b0, 0, 0);
        send_sample(1'b0, 1023, 1023);
        send_sample(1'b1, 0, 1023);
        send_sample(1'b1, 512, 462);
        send_sample(1'b1, 512, 461);
        repeat (8) send_sample(1'b0, 487, 1023);
        send_sample(1'b0, 486, 1023);
        repeat (7) send_sample(1'b1, 537, 0);
        send_sample(1'b1, 545, 0);
        stop_sending();
        wait_drained();

        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: set_centres(rand_reg(0, 1023), rand_reg(0, 1023),
                               rand_reg(0, 1023), rand_reg(0, 1023),
                               rand_reg(0, 300), rand_reg(0, 100));
                1: set_centres(10'd0, 10'd0, 10'd1023, 10'd1023, 10'd0, 10'd0);
                2: set_centres(10'd1023, 10'd0, 10'd0, 10'd1023, 10'd1023, 10'd1023);
                3: set_centres(rand_reg(300, 700), rand_reg(300, 700),
                               rand_reg(300, 700), rand_reg(300, 700),
                               rand_reg(0, 120), rand_reg(0, 60));
                4: set_centres(rand_reg(0, 1023), rand_reg(0, 1023),
                               rand_reg(0, 1023), rand_reg(0, 1023),
                               rand_reg(0, 20), rand_reg(0, 40));
                default: set_centres(CENTRE_RESET, CENTRE_RESET, CENTRE_RESET, CENTRE_RESET,
                                     RADIUS_RESET, MARGIN_RESET);
            endcase
            if (phase == 3) begin
                hold_cycles = 80;
                tx_quiet    = 1'b1;
                for (int n = 0; n < 30; n++)
                    send_sample(1'($urandom_range(0, 1)), $urandom_range(0, 1023),
                                $urandom_range(0, 1023));
            end
            random_samples(PHASE_WORDS);
            wait_drained();
        end

        if (filt.mismatches == 0 && filt.pending_reports.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

`default_nettype wire
